>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, ignored while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same check, used by the encoder checker.
`define ASSERT_WLE(label, prop, msg) \
	`ASSERT_CLK(label, prop, msg)

`endif

>>> rtl/wle_pkg.sv
// ----------------------------------------------------------------------------
// wle_pkg
// Types and constants shared by the LED one-wire encoder modules.
// ----------------------------------------------------------------------------
package wle_pkg;

	// Width of every timing register and of the colour byte
	localparam int CFG_W  = 16;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_POWER_ON    = 3'd0;
	localparam logic [IDX_W-1:0] REG_ONE_HIGH    = 3'd1;
	localparam logic [IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
	localparam logic [IDX_W-1:0] REG_BIT_PERIOD  = 3'd3;
	localparam logic [IDX_W-1:0] REG_RESET_TICKS = 3'd4;

	// Reset values of the timing registers
	localparam logic [CFG_W-1:0] RST_ONE_HIGH    = 16'd11;
	localparam logic [CFG_W-1:0] RST_ZERO_HIGH   = 16'd6;
	localparam logic [CFG_W-1:0] RST_BIT_PERIOD  = 16'd20;
	localparam logic [CFG_W-1:0] RST_RESET_TICKS = 16'd800;

	typedef struct packed {
		logic             power_on;
		logic [CFG_W-1:0] one_high;
		logic [CFG_W-1:0] zero_high;
		logic [CFG_W-1:0] bit_period;
		logic [CFG_W-1:0] reset_ticks;
	} cfg_t;

	// One tick as offered on the input channel
	typedef struct packed {
		logic              byte_valid;
		logic [BYTE_W-1:0] byte_value;
		logic              frame_last;
	} item_t;

	// Head of the item queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// One result item
	typedef struct packed {
		logic data_pin;
		logic power_pin;
		logic ready_res;
		logic rejected;
		logic frame_done;
	} result_t;

endpackage

>>> rtl/wle_front.sv
// ----------------------------------------------------------------------------
// wle_front
// Input side: takes tick items and holds them in a two-entry queue so that
// the input and the pulse engine stall independently.
// ----------------------------------------------------------------------------
module wle_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wle_pkg::item_t  in_item,
	output wle_pkg::head_t  head,
	input  logic            pop
);
	import wle_pkg::*;

	localparam int DEPTH = 2;

	item_t      slot_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       take;

	// Accept while a slot is free
	assign in_ready = (count_q != 2'(DEPTH));
	assign push     = in_valid && in_ready;
	assign take     = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	// Store the item payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/wle_back.sv
// ----------------------------------------------------------------------------
// wle_back
// Pulse engine: steps the bit-cell and latch timers once per tick item and
// registers the resulting pin levels in the output stage.
// ----------------------------------------------------------------------------
module wle_back #(
	parameter int BITS_PER_BYTE = 8,
	parameter int TIMER_WIDTH   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wle_pkg::cfg_t     cfg,
	input  wle_pkg::head_t    head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output wle_pkg::result_t  res
);
	import wle_pkg::*;

	localparam int CW  = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam int BLW = $clog2(BITS_PER_BYTE + 1);
	localparam int SW  = (BITS_PER_BYTE > BYTE_W) ? BITS_PER_BYTE : BYTE_W;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_SEND  = 3'b010,
		PH_LATCH = 3'b100
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [BITS_PER_BYTE-1:0] shift_q, shift_d;
	logic [BLW-1:0]           bits_q, bits_d, bits_dec;
	logic [TIMER_WIDTH-1:0]   tick_q, tick_d;
	logic                     latch_q, latch_d;
	logic                     out_valid_q;
	result_t                  res_q, res_d;

	logic [TIMER_WIDTH:0]     tick_inc;
	logic [TIMER_WIDTH-1:0]   high_lim;
	logic [TIMER_WIDTH-1:0]   per_lim;
	logic [TIMER_WIDTH-1:0]   rst_lim;
	logic [SW-1:0]            value_ext;
	logic                     cur_bit;

	// Saturate a register value to the timer range
	function automatic logic [TIMER_WIDTH-1:0] cap(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ve;
		logic [CW-1:0] maxv;
		ve   = CW'(v);
		maxv = CW'({TIMER_WIDTH{1'b1}});
		return (ve > maxv) ? maxv[TIMER_WIDTH-1:0] : ve[TIMER_WIDTH-1:0];
	endfunction

	// Saturate and treat zero as one
	function automatic logic [TIMER_WIDTH-1:0] limit(input logic [CFG_W-1:0] v);
		logic [TIMER_WIDTH-1:0] c;
		c = cap(v);
		return (c == '0) ? TIMER_WIDTH'(1) : c;
	endfunction

	// Take the next item whenever the output stage is free or being drained
	assign pop       = head.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign cur_bit   = shift_q[BITS_PER_BYTE-1];
	assign high_lim  = cap(cur_bit ? cfg.one_high : cfg.zero_high);
	assign per_lim   = limit(cfg.bit_period);
	assign rst_lim   = limit(cfg.reset_ticks);
	assign tick_inc  = {1'b0, tick_q} + (TIMER_WIDTH+1)'(1);
	assign value_ext = SW'(head.item.byte_value);
	assign bits_dec  = (bits_q != '0) ? bits_q - BLW'(1) : '0;

	// Step the encoder for one tick
	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		tick_d  = tick_q;
		latch_d = latch_q;
		res_d            = '0;
		res_d.power_pin  = cfg.power_on;
		if (!cfg.power_on) begin
			// Power off: abort everything and refuse the byte
			phase_d        = PH_IDLE;
			bits_d         = '0;
			tick_d         = '0;
			latch_d        = 1'b0;
			res_d.rejected = head.item.byte_valid;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (head.item.byte_valid) begin
						res_d.ready_res = 1'b1;
						shift_d = value_ext[BITS_PER_BYTE-1:0];
						bits_d  = BLW'(BITS_PER_BYTE);
						tick_d  = '0;
						latch_d = head.item.frame_last;
						phase_d = PH_SEND;
					end
				end
				PH_SEND: begin
					res_d.data_pin = (tick_q < high_lim);
					if (tick_inc >= {1'b0, per_lim}) begin
						tick_d  = '0;
						shift_d = shift_q << 1;
						bits_d  = bits_dec;
						if (bits_dec == '0) begin
							phase_d = latch_q ? PH_LATCH : PH_IDLE;
						end
					end else begin
						tick_d = tick_inc[TIMER_WIDTH-1:0];
					end
				end
				PH_LATCH: begin
					if (tick_inc >= {1'b0, rst_lim}) begin
						res_d.frame_done = 1'b1;
						tick_d  = '0;
						latch_d = 1'b0;
						phase_d = PH_IDLE;
					end else begin
						tick_d = tick_inc[TIMER_WIDTH-1:0];
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Hold encoder state and the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			bits_q      <= '0;
			tick_q      <= '0;
			latch_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				bits_q      <= bits_d;
				tick_q      <= tick_d;
				latch_q     <= latch_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

>>> rtl/ws2812_serial_led_encoder.sv
// ----------------------------------------------------------------------------
// ws2812_serial_led_encoder
// One-wire LED encoder: tick items in, pin levels out, one result per item.
// ----------------------------------------------------------------------------
// Every input item is one tick of the LED timing and yields exactly one result
// item with the data and power pin levels for that tick. The block takes one
// item per clock cycle unless out_ready stalls the output: a two-entry queue
// feeds a pulse engine that steps its timers once per item, and a registered
// output stage holds the result, so an item passes the queue register and then
// the output register. Bytes go out MSB first as bit cells of bit_period ticks,
// high for one_high or zero_high ticks; after a byte marked frame_last the line
// is held low for reset_ticks ticks and frame_done pulses on the last of them.
// Configuration writes take effect on the next cycle and are accepted always.
// ----------------------------------------------------------------------------
module ws2812_serial_led_encoder #(
	parameter int BITS_PER_BYTE = 8,
	parameter int TIMER_WIDTH   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        byte_valid,
	input  logic [wle_pkg::BYTE_W-1:0]  byte_value,
	input  logic                        frame_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        data_pin,
	output logic                        power_pin,
	output logic                        ready_res,
	output logic                        rejected,
	output logic                        frame_done,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wle_pkg::IDX_W-1:0]   cfg_index,
	input  logic [wle_pkg::CFG_W-1:0]   cfg_data
);
	import wle_pkg::*;

	cfg_t    cfg_q;
	item_t   in_item;
	head_t   head;
	logic    pop;
	result_t res;

	assign cfg_ready = 1'b1;

	// Configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_on    <= 1'b0;
			cfg_q.one_high    <= RST_ONE_HIGH;
			cfg_q.zero_high   <= RST_ZERO_HIGH;
			cfg_q.bit_period  <= RST_BIT_PERIOD;
			cfg_q.reset_ticks <= RST_RESET_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POWER_ON:    cfg_q.power_on    <= cfg_data[0];
				REG_ONE_HIGH:    cfg_q.one_high    <= cfg_data;
				REG_ZERO_HIGH:   cfg_q.zero_high   <= cfg_data;
				REG_BIT_PERIOD:  cfg_q.bit_period  <= cfg_data;
				REG_RESET_TICKS: cfg_q.reset_ticks <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	assign in_item.byte_valid = byte_valid;
	assign in_item.byte_value = byte_value;
	assign in_item.frame_last = frame_last;

	wle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	wle_back #(
		.BITS_PER_BYTE (BITS_PER_BYTE),
		.TIMER_WIDTH   (TIMER_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign data_pin   = res.data_pin;
	assign power_pin  = res.power_pin;
	assign ready_res  = res.ready_res;
	assign rejected   = res.rejected;
	assign frame_done = res.frame_done;

endmodule

>>> rtl/wle_checker.sv
// ----------------------------------------------------------------------------
// wle_checker
// Port-level checks on the encoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wle_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic data_pin,
	input logic power_pin,
	input logic ready_res,
	input logic rejected,
	input logic frame_done
);

	logic       busy_pins;
	logic       pin_event;
	logic       stalled;
	logic [4:0] pins;

	// Gather the result pins and the stall condition
	assign busy_pins = data_pin || ready_res || frame_done;
	assign pin_event = ready_res || frame_done;
	assign stalled   = out_valid && !out_ready;
	assign pins      = {data_pin, power_pin, ready_res, rejected, frame_done};

	// Power off keeps the line low and allows no accept or latch completion
	`ASSERT_WLE(a_power_off_quiet, out_valid && !power_pin |-> !busy_pins, "power off activity")

	// A byte is either accepted or rejected, never both, and never while on
	`ASSERT_WLE(a_reject_off, out_valid && rejected |-> !power_pin && !ready_res, "reject while on")

	// The line is low on the accept tick and on the latch completion tick
	`ASSERT_WLE(a_low_on_events, out_valid && pin_event |-> !data_pin, "line high on event")

	// A stalled result holds its pin levels
	`ASSERT_WLE(a_stall_hold, stalled |=> out_valid && $stable(pins), "stall changed result")

endmodule

bind ws2812_serial_led_encoder wle_checker u_wle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.data_pin   (data_pin),
	.power_pin  (power_pin),
	.ready_res  (ready_res),
	.rejected   (rejected),
	.frame_done (frame_done)
);
